[rtl/fehc_pkg.sv]
// Shared constants and types for the FIFO-evicting handle cache.
// No dependencies; used by fehc_cell and fifo_evicting_handle_cache.
package fehc_pkg;

  // Cache geometry
  localparam int unsigned MAX_ENTRIES = 30;   // 2..31
  localparam int unsigned HANDLE_BITS = 32;   // 8..64, stored bits of a handle
  localparam int unsigned HANDLE_W    = 32;   // handle field width on the ports
  localparam int unsigned CELL_W      = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned CMP_W       = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;
  localparam int unsigned SIDE_W      = 16;
  localparam int unsigned HITS_W      = 32;
  localparam int unsigned MIN_LIMIT   = 2;

  // Beat layouts
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_RESET    = 3'd1,
    ST_BAD_SIZE    = 3'd2,
    ST_DECODE_FAIL = 3'd3,
    ST_BAD_LIMIT   = 3'd4,
    ST_BAD_INDEX   = 3'd5
  } status_e;

  // Per-cell update command
  typedef struct packed {
    logic load;   // take the incoming handle
    logic shift;  // take the neighbor's handle (oldest side drops out)
  } cell_ctrl_t;

endpackage

[rtl/fehc_cell.sv]
// One storage cell of the handle chain: holds a single handle.
// Depends on fehc_pkg (widths, cell_ctrl_t).
module fehc_cell (
  input  logic                         clk_i,
  input  fehc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [fehc_pkg::CELL_W-1:0]  new_i,
  input  logic [fehc_pkg::CELL_W-1:0]  next_i,
  output logic [fehc_pkg::CELL_W-1:0]  data_o
);

  logic [fehc_pkg::CELL_W-1:0] data_q;
  logic [fehc_pkg::CELL_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = new_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/fifo_evicting_handle_cache.sv]
// Top level of the FIFO-evicting handle cache: control, hit counter, output beat.
// Depends on fehc_pkg and fehc_cell.
//
// Usage:
//   Slave stream carries requests. tuser is func: 0 stores a new shape handle,
//   1 reads a cached entry. A new shape is checked for size 1..16383 on both
//   sides and for decode_ok; with reset_request it first clears the cache and
//   sets the limit (2..MAX_ENTRIES) from slot_or_limit. The handle is appended;
//   when the cache is at its limit the oldest entry drops out and the row of
//   cells shifts one place toward index 0. A reference counts a hit and
//   returns the entry at slot_or_limit.
//   Master stream gives exactly one result beat per request beat.
// Result and rate:
//   Result registered, shown the cycle after accept. One request per cycle unless
//   the receiver stalls: the whole cell row updates from a one-level select.
// Reset:
//   Cache empty, no limit set (references answer "no reset yet"), hits zero,
//   no result pending. Stored handles are not cleared.
// Stall:
//   s_axis_tready is high while the output register is empty or being taken,
//   so a stalled receiver holds at most one result and back-pressures input.
module fifo_evicting_handle_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [0] reset_request, [5:1] slot_or_limit, [21:6] shape_width,
  // [37:22] shape_height, [38] decode_ok, [70:39] shape_handle, [71] zero
  input  logic [fehc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic        s_axis_tuser,        // [0] func
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] status, [34:3] result_handle, [39:35] entries_used, [71:40] hit_count
  output logic [fehc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int unsigned N = fehc_pkg::MAX_ENTRIES;

  // ---------------- input fields ----------------
  logic                            func;
  logic                            rst_req;
  logic [fehc_pkg::SLOT_W-1:0]     slot;
  logic [fehc_pkg::SIDE_W-1:0]     side_w;
  logic [fehc_pkg::SIDE_W-1:0]     side_h;
  logic                            decode_ok;
  logic [fehc_pkg::HANDLE_W-1:0]   handle_in;
  logic [fehc_pkg::CELL_W-1:0]     handle_cell;

  assign func        = s_axis_tuser;
  assign rst_req     = s_axis_tdata[0];
  assign slot        = s_axis_tdata[5:1];
  assign side_w      = s_axis_tdata[21:6];
  assign side_h      = s_axis_tdata[37:22];
  assign decode_ok   = s_axis_tdata[38];
  assign handle_in   = s_axis_tdata[70:39];
  assign handle_cell = handle_in[fehc_pkg::CELL_W-1:0];

  // ---------------- state ----------------
  logic [fehc_pkg::CNT_W-1:0]   count_q, count_d;
  logic [fehc_pkg::CNT_W-1:0]   limit_q, limit_d;
  logic                         limit_set_q, limit_set_d;
  logic [fehc_pkg::HITS_W-1:0]  hits_q, hits_d;

  logic                         out_valid_q;
  fehc_pkg::status_e            out_status_q, status_d;
  logic [fehc_pkg::HANDLE_W-1:0] out_handle_q, handle_d;
  logic [fehc_pkg::CNT_W-1:0]   out_count_q;
  logic [fehc_pkg::HITS_W-1:0]  out_hits_q;

  logic accept;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------- cell row ----------------
  logic [fehc_pkg::CELL_W-1:0] cell_data [N];
  fehc_pkg::cell_ctrl_t        cell_ctrl [N];

  logic                        wr_en;    // a handle goes into the row
  logic                        evict;    // drop oldest, shift row
  logic [fehc_pkg::CNT_W-1:0]  wr_tgt;   // cell that takes the new handle

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [fehc_pkg::CELL_W-1:0] next_data;
    if (i == N - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    always_comb begin
      cell_ctrl[i].load  = wr_en && (wr_tgt == fehc_pkg::CNT_W'(i));
      cell_ctrl[i].shift = wr_en && evict && (fehc_pkg::CNT_W'(i) < wr_tgt);
    end

    fehc_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .new_i  (handle_cell),
      .next_i (next_data),
      .data_o (cell_data[i])
    );
  end

  // ---------------- request decode ----------------
  logic                       size_ok;
  logic [fehc_pkg::CMP_W-1:0] slot_x;
  logic [fehc_pkg::CMP_W-1:0] count_x;
  logic [fehc_pkg::CNT_W-1:0] count_eff;
  logic [fehc_pkg::CNT_W-1:0] limit_eff;
  logic [fehc_pkg::CNT_W-1:0] keep_n;
  logic [fehc_pkg::CELL_W-1:0] rd_data;

  // side in 1..16383: top two bits clear and not zero (negatives fail too)
  assign size_ok = (side_w[15:14] == 2'b00) && (side_w != '0) &&
                   (side_h[15:14] == 2'b00) && (side_h != '0);

  assign slot_x  = fehc_pkg::CMP_W'(slot);
  assign count_x = fehc_pkg::CMP_W'(count_q);
  assign rd_data = cell_data[slot[fehc_pkg::IDX_W-1:0]];

  always_comb begin
    count_d     = count_q;
    limit_d     = limit_q;
    limit_set_d = limit_set_q;
    hits_d      = hits_q;
    status_d    = fehc_pkg::ST_OK;
    handle_d    = '0;
    wr_en       = 1'b0;
    evict       = 1'b0;
    wr_tgt      = '0;
    count_eff   = count_q;
    limit_eff   = limit_q;
    keep_n      = count_q;

    if (func) begin
      if (!limit_set_q) begin
        status_d = fehc_pkg::ST_NO_RESET;
      end else begin
        hits_d = hits_q + 1'b1;
        if (slot_x >= count_x || slot_x >= fehc_pkg::CMP_W'(N)) begin
          status_d = fehc_pkg::ST_BAD_INDEX;
        end else begin
          handle_d = fehc_pkg::HANDLE_W'(rd_data);
        end
      end
    end else if (!size_ok) begin
      status_d = fehc_pkg::ST_BAD_SIZE;
    end else if (!decode_ok) begin
      status_d = fehc_pkg::ST_DECODE_FAIL;
    end else if (rst_req && (slot_x < fehc_pkg::CMP_W'(fehc_pkg::MIN_LIMIT) ||
                             slot_x > fehc_pkg::CMP_W'(N))) begin
      status_d = fehc_pkg::ST_BAD_LIMIT;
    end else if (!rst_req && !limit_set_q) begin
      status_d = fehc_pkg::ST_NO_RESET;
    end else begin
      if (rst_req) begin
        limit_eff   = slot[fehc_pkg::CNT_W-1:0];
        count_eff   = '0;
        limit_d     = limit_eff;
        limit_set_d = 1'b1;
      end
      wr_en    = 1'b1;
      handle_d = fehc_pkg::HANDLE_W'(handle_cell);
      if (count_eff < limit_eff && count_eff < fehc_pkg::CNT_W'(N)) begin
        wr_tgt  = count_eff;
        count_d = count_eff + 1'b1;
      end else begin
        // full: oldest drops, newest lands at the top of the kept run
        keep_n = (count_eff > fehc_pkg::CNT_W'(N)) ? fehc_pkg::CNT_W'(N) : count_eff;
        if (keep_n == '0) begin
          keep_n = fehc_pkg::CNT_W'(1);
        end
        evict   = 1'b1;
        wr_tgt  = keep_n - 1'b1;
        count_d = keep_n;
      end
    end

    if (!accept) begin
      wr_en = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= '0;
      limit_set_q <= 1'b0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        limit_q     <= limit_d;
        limit_set_q <= limit_set_d;
        hits_q      <= hits_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_handle_q <= handle_d;
      out_count_q  <= count_d;
      out_hits_q   <= hits_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hits_q,
                          fehc_pkg::SLOT_W'(out_count_q),
                          out_handle_q,
                          3'(out_status_q)};

  // ---------------- assertions ----------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fehc_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_set_q |-> (count_q <= limit_q))
    else $error("entry count above programmed limit");

  a_hits_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(hits_q))
    else $error("hit counter moved without a request");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != fehc_pkg::ST_OK) |-> (out_handle_q == '0))
    else $error("error result carries a handle");

endmodule

[dv/fehc_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the FIFO-evicting handle cache: watches the request and result
// streams, predicts every result beat and compares it field by field.
// Depends on fehc_pkg.
module fehc_checker #(
  parameter logic FUNC_REF = 1'b1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [fehc_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            s_tuser_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [fehc_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import fehc_pkg::*;

  localparam logic [15:0] MAX_SIDE = 16'd16383;
  localparam logic [31:0] HANDLE_MASK = (CELL_W >= 32) ? 32'hFFFF_FFFF
                                                       : ((32'd1 << CELL_W) - 32'd1);

  typedef struct packed {
    status_e     status;
    logic [31:0] handle;
    logic [4:0]  used;
    logic [31:0] hits;
  } cache_resp_t;

  // Shadow of the cache, oldest entry at index 0
  logic [31:0]      shadow_q [MAX_ENTRIES];
  logic [CNT_W-1:0] used_q;
  logic [4:0]       limit_q;
  logic             armed_q;
  logic [31:0]      hits_q;

  cache_resp_t expected_q [$];
  cache_resp_t want, got;
  int unsigned errs;

  function automatic bit side_in_range(logic [15:0] v);
    return (v >= 16'd1) && (v <= MAX_SIDE);
  endfunction

  function automatic int unsigned field_mismatch(string name, logic [31:0] exp_v,
                                                 logic [31:0] act_v);
    if (exp_v === act_v) return 0;
    $display("%0t ns: mismatch on %s: expected 0x%08h, got 0x%08h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  task automatic predict_beat(input logic [IN_TDATA_W-1:0] d, input logic func,
                              output cache_resp_t r);
    logic        rst_req;
    logic [4:0]  slot;
    logic [15:0] w, h;
    logic        dec_ok;
    logic [31:0] hnd;
    int unsigned n;
    rst_req = d[0];
    slot    = d[5:1];
    w       = d[21:6];
    h       = d[37:22];
    dec_ok  = d[38];
    hnd     = d[70:39] & HANDLE_MASK;
    r.handle = '0;
    if (func == FUNC_REF) begin
      // reset_request is ignored on references
      if (!armed_q) begin
        r.status = ST_NO_RESET;
      end else begin
        hits_q = hits_q + 32'd1;
        if (slot >= used_q || slot >= MAX_ENTRIES) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.status = ST_OK;
          r.handle = shadow_q[slot];
        end
      end
    end else if (!side_in_range(w) || !side_in_range(h)) begin
      r.status = ST_BAD_SIZE;
    end else if (!dec_ok) begin
      r.status = ST_DECODE_FAIL;
    end else if (rst_req && (slot < MIN_LIMIT || slot > MAX_ENTRIES)) begin
      r.status = ST_BAD_LIMIT;
    end else begin
      if (rst_req) begin
        limit_q = slot;
        armed_q = 1'b1;
        used_q  = '0;
      end
      if (!armed_q) begin
        r.status = ST_NO_RESET;
      end else begin
        if (used_q < limit_q && used_q < MAX_ENTRIES) begin
          shadow_q[used_q] = hnd;
          used_q = used_q + 1'b1;
        end else begin
          // full: oldest drops out, row moves toward index 0
          n = 32'(used_q);
          if (n > MAX_ENTRIES) n = MAX_ENTRIES;
          if (n == 0) n = 1;
          for (int i = 0; i < int'(n) - 1; i++) shadow_q[i] = shadow_q[i+1];
          shadow_q[n-1] = hnd;
          used_q = CNT_W'(n);
        end
        r.status = ST_OK;
        r.handle = shadow_q[used_q-1];
      end
    end
    r.used = used_q;
    r.hits = hits_q;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      used_q       = '0;
      limit_q      = '0;
      armed_q      = 1'b0;
      hits_q       = '0;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // result first: it always belongs to an earlier request
      if (m_tvalid_i && m_tready_i) begin
        got.status = status_e'(m_tdata_i[2:0]);
        got.handle = m_tdata_i[34:3];
        got.used   = m_tdata_i[39:35];
        got.hits   = m_tdata_i[71:40];
        if (expected_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, got 0x%018h",
                   $time, m_tdata_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          errs = field_mismatch("status", 32'(want.status), 32'(got.status))
               + field_mismatch("result_handle", want.handle, got.handle)
               + field_mismatch("entries_used", 32'(want.used), 32'(got.used))
               + field_mismatch("hit_count", want.hits, got.hits);
          fail_count_o = fail_count_o + errs;
          checked_o = checked_o + 1;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_beat(s_tdata_i, s_tuser_i, want);
        expected_q.push_back(want);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

[dv/tb_fifo_evicting_handle_cache.sv]
`timescale 1ns / 100ps
// Testbench top for fifo_evicting_handle_cache: drives request beats, random
// stalls on both streams, and reports the verdict. Depends on fehc_pkg, fehc_checker.
module tb_fifo_evicting_handle_cache;
  import fehc_pkg::*;

  // tuser codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_REF   = 1'b1;

  localparam int unsigned N_RANDOM    = 700;
  localparam int unsigned IDLE_PCT    = 26;      // percent of idle cycles per side
  localparam int unsigned CALM_FIRST  = 250;     // first random beat without any idling
  localparam int unsigned CALM_LAST   = 400;
  localparam int unsigned TAIL_CYCLES = 8;       // idle margin after the drain
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        func;
    logic        rst_req;
    logic [4:0]  slot;
    logic [15:0] w;
    logic [15:0] h;
    logic        dec_ok;
    logic [31:0] hnd;
  } shape_beat_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  int unsigned fail_count, pending, checked;
  int unsigned beats_sent  = 0;
  int unsigned resets_sent = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;   // no idling on either side while set

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fifo_evicting_handle_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  fehc_checker #(.FUNC_REF(FUNC_REF)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver stalls, changed on the falling edge like every other input
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic shape_beat_t mk(logic func, logic rst_req, logic [4:0] slot,
                                     logic [15:0] w, logic [15:0] h, logic dec_ok,
                                     logic [31:0] hnd);
    shape_beat_t b;
    b.func    = func;
    b.rst_req = rst_req;
    b.slot    = slot;
    b.w       = w;
    b.h       = h;
    b.dec_ok  = dec_ok;
    b.hnd     = hnd;
    return b;
  endfunction

  // Mostly well-formed traffic: rare cache resets, appends with legal sizes,
  // lookups biased toward small indexes; the rest is raw noise.
  function automatic shape_beat_t rand_beat();
    shape_beat_t b;
    int unsigned pick;
    pick = $urandom_range(99);
    b = mk(FUNC_STORE, 1'b0, 5'($urandom_range(31)), 16'($urandom_range(16383, 1)),
           16'($urandom_range(16383, 1)), 1'b1, $urandom);
    if (pick < 3) begin
      b.rst_req = 1'b1;
      b.slot    = ($urandom_range(3) == 0) ? 5'($urandom_range(4, 2))
                                          : 5'($urandom_range(MAX_ENTRIES, 2));
    end else if (pick < 55) begin
      b.rst_req = 1'b0;
    end else if (pick < 90) begin
      b.func    = FUNC_REF;
      b.rst_req = 1'($urandom_range(1));
      b.slot    = $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
    end else begin
      b.func    = 1'($urandom_range(1));
      b.rst_req = 1'($urandom_range(1));
      b.w       = 16'($urandom);
      b.h       = 16'($urandom);
      b.dec_ok  = 1'($urandom_range(1));
    end
    return b;
  endfunction

  // Present one request beat and hold it until accepted; runs from a falling edge
  task automatic push_beat(input shape_beat_t b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, b.hnd, b.dec_ok, b.h, b.w, b.slot, b.rst_req};
    s_axis_tuser  <= b.func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent = beats_sent + 1;
    if (b.func == FUNC_STORE && b.rst_req) resets_sent = resets_sent + 1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: before any cache reset
    push_beat(mk(FUNC_REF,   1'b0, 5'd0,  16'd5,     16'd5,     1'b1, 32'h1111_1111));
    push_beat(mk(FUNC_STORE, 1'b0, 5'd0,  16'd5,     16'd5,     1'b1, 32'h2222_2222));
    // limits outside 2..MAX_ENTRIES
    push_beat(mk(FUNC_STORE, 1'b1, 5'd0,  16'd5,     16'd5,     1'b1, 32'h3333_3333));
    push_beat(mk(FUNC_STORE, 1'b1, 5'd1,  16'd5,     16'd5,     1'b1, 32'h3333_3333));
    push_beat(mk(FUNC_STORE, 1'b1, 5'd31, 16'd5,     16'd5,     1'b1, 32'h3333_3333));
    // size checks: zero, one past the max, most negative, -1 with a bad decode
    push_beat(mk(FUNC_STORE, 1'b1, 5'd4,  16'd0,     16'd5,     1'b1, 32'h4444_4444));
    push_beat(mk(FUNC_STORE, 1'b1, 5'd4,  16'd16384, 16'd5,     1'b1, 32'h4444_4444));
    push_beat(mk(FUNC_STORE, 1'b1, 5'd4,  16'd5,     16'h8000,  1'b1, 32'h4444_4444));
    push_beat(mk(FUNC_STORE, 1'b1, 5'd4,  16'hFFFF,  16'd5,     1'b0, 32'h4444_4444));
    // decode failure wins over a bad limit
    push_beat(mk(FUNC_STORE, 1'b1, 5'd31, 16'd16383, 16'd16383, 1'b0, 32'h5555_5555));
    // smallest limit, fill and evict
    push_beat(mk(FUNC_STORE, 1'b1, 5'd2,  16'd1,     16'd16383, 1'b1, 32'hFFFF_FFFF));
    push_beat(mk(FUNC_STORE, 1'b0, 5'd0,  16'd1,     16'd1,     1'b1, 32'h0000_0000));
    push_beat(mk(FUNC_STORE, 1'b0, 5'd0,  16'd16383, 16'd1,     1'b1, 32'hA5A5_A5A5));
    push_beat(mk(FUNC_REF,   1'b0, 5'd0,  16'd0,     16'd0,     1'b0, 32'h0));
    push_beat(mk(FUNC_REF,   1'b0, 5'd1,  16'd0,     16'd0,     1'b0, 32'h0));
    push_beat(mk(FUNC_REF,   1'b0, 5'd2,  16'd0,     16'd0,     1'b0, 32'h0));
    // reset request on a reference is ignored
    push_beat(mk(FUNC_REF,   1'b1, 5'd31, 16'hFFFF,  16'hFFFF,  1'b1, 32'hFFFF_FFFF));
    // bad limit once armed keeps the old contents
    push_beat(mk(FUNC_STORE, 1'b1, 5'd31, 16'd7,     16'd7,     1'b1, 32'h6666_6666));
    push_beat(mk(FUNC_REF,   1'b0, 5'd1,  16'd0,     16'd0,     1'b0, 32'h0));
    // largest limit
    push_beat(mk(FUNC_STORE, 1'b1, 5'(MAX_ENTRIES), 16'd16383, 16'd1, 1'b1, 32'h5A5A_5A5A));
    push_beat(mk(FUNC_STORE, 1'b0, 5'd0,  16'h7FFF,  16'd1,     1'b1, 32'h7777_7777));
    push_beat(mk(FUNC_REF,   1'b0, 5'd0,  16'd0,     16'd0,     1'b0, 32'h0));
    push_beat(mk(FUNC_STORE, 1'b1, 5'd3,  16'd9,     16'd9,     1'b1, 32'h8888_8888));
    push_beat(mk(FUNC_REF,   1'b0, 5'd0,  16'd0,     16'd0,     1'b0, 32'h0));

    // Random traffic with a stall-free stretch in the middle
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      calm = (i >= CALM_FIRST) && (i < CALM_LAST);
      push_beat(rand_beat());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then wait out the TAIL_CYCLES margin
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d request beats (%0d cache resets), checked %0d result beats",
             beats_sent, resets_sent, checked);
    $display("mismatches: %0d, results left waiting: %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
